// ----- sv/lcd_color_correct_blend_rotate_assert.svh -----
// Assertion macros shared by the frame blend RTL.
`ifndef LCD_COLOR_CORRECT_BLEND_ROTATE_ASSERT_SVH
`define LCD_COLOR_CORRECT_BLEND_ROTATE_ASSERT_SVH

`ifndef SYNTHESIS

`define LCCBR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`define LCCBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`define LCCBR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: label");

`else

`define LCCBR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LCCBR_ASSERT_NEXT(label, clk, rst, ante, cons)
`define LCCBR_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- sv/lccbr_pkg.sv -----
// Types, constants and register codes of the color correct, blend and rotate block.
`default_nettype none

package lccbr_pkg;

   localparam int SCREEN_SIDE = 224;
   localparam int IMAGE_ROWS  = 144;
   localparam int BORDER      = 40;

   localparam int FRAME_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);

   localparam int PIX_W   = 12;
   localparam int NIB_W   = 4;
   localparam int COORD_W = 8;
   localparam int CHAN_W  = 8;
   localparam int SUM_W   = 9;
   // wide enough for BORDER + 255 and for SCREEN_SIDE - 1
   localparam int DEST_W  = 11;

   localparam logic [SUM_W-1:0] CLAMP_MAX = SUM_W'(480);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_EMULATION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_ENABLE     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATED         = CSR_IDX_W'(2);

   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   localparam int RGB_W = $bits(rgb_type);

   typedef struct packed {
      logic color_emulation;
      logic blur_enable;
      logic rotated;
   } cfg_type;

   typedef struct packed {
      rgb_type            color;
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
      logic               hit;
      logic [ADDR_W-1:0]  addr;
   } front_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
      rgb_type            color;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/lccbr_req_if.sv -----
// Request channel: source pixel with its source position.
`default_nettype none

interface lccbr_req_if
   import lccbr_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_color;
   logic [COORD_W-1:0] src_col;
   logic [COORD_W-1:0] src_row;

   modport source (output valid, output pixel_color, output src_col, output src_row,
                   input ready);
   modport sink   (input valid, input pixel_color, input src_col, input src_row,
                   output ready);
endinterface

`default_nettype wire

// ----- sv/lccbr_rsp_if.sv -----
// Response channel: destination position and final color.
`default_nettype none

interface lccbr_rsp_if
   import lccbr_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] dest_row;
   logic [COORD_W-1:0] dest_col;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   modport source (output valid, output dest_row, output dest_col, output red,
                   output green, output blue, input ready);
   modport sink   (input valid, input dest_row, input dest_col, input red,
                   input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- sv/lccbr_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none

module lccbr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/lccbr_convert.sv -----
// Color conversion and destination placement of one request.
`default_nettype none

module lccbr_convert
   import lccbr_pkg::*;
(
   input  wire logic [PIX_W-1:0]   pixel_color,
   input  wire logic [COORD_W-1:0] src_col,
   input  wire logic [COORD_W-1:0] src_row,
   input  wire cfg_type            cfg,
   output      front_type          front
);

   localparam logic [DEST_W-1:0] SIDE_D   = DEST_W'(SCREEN_SIDE);
   localparam logic [DEST_W-1:0] ROWS_D   = DEST_W'(IMAGE_ROWS);
   localparam logic [DEST_W-1:0] BORDER_D = DEST_W'(BORDER);
   localparam logic [DEST_W-1:0] LAST_D   = DEST_W'(SCREEN_SIDE - 1);

   logic [NIB_W-1:0]  r_nib, g_nib, b_nib;
   logic [SUM_W-1:0]  r9, g9, b9;
   logic [SUM_W-1:0]  r_sum, g_sum, b_sum;
   logic [SUM_W-1:0]  r_clp, g_clp, b_clp;
   rgb_type           color;
   logic [DEST_W-1:0] col_d, row_d, drow_d, dcol_d;
   logic              src_ok;

   assign b_nib = pixel_color[NIB_W-1:0];
   assign g_nib = pixel_color[2*NIB_W-1:NIB_W];
   assign r_nib = pixel_color[3*NIB_W-1:2*NIB_W];

   assign r9 = SUM_W'(r_nib);
   assign g9 = SUM_W'(g_nib);
   assign b9 = SUM_W'(b_nib);

   // LCD correction matrix, each row sums to at most 480
   assign r_sum = r9 * SUM_W'(26) + g9 * SUM_W'(4) + b9 * SUM_W'(2);
   assign g_sum = g9 * SUM_W'(24) + b9 * SUM_W'(8);
   assign b_sum = r9 * SUM_W'(6) + g9 * SUM_W'(4) + b9 * SUM_W'(22);

   assign r_clp = (r_sum > CLAMP_MAX) ? CLAMP_MAX : r_sum;
   assign g_clp = (g_sum > CLAMP_MAX) ? CLAMP_MAX : g_sum;
   assign b_clp = (b_sum > CLAMP_MAX) ? CLAMP_MAX : b_sum;

   always_comb begin
      if (cfg.color_emulation) begin
         color.red   = r_clp[SUM_W-1:1];
         color.green = g_clp[SUM_W-1:1];
         color.blue  = b_clp[SUM_W-1:1];
      end else begin
         color.red   = {r_nib, r_nib};
         color.green = {g_nib, g_nib};
         color.blue  = {b_nib, b_nib};
      end
   end

   assign col_d = DEST_W'(src_col);
   assign row_d = DEST_W'(src_row);

   always_comb begin
      if (cfg.rotated) begin
         drow_d = LAST_D - col_d;
         dcol_d = BORDER_D + row_d;
      end else begin
         drow_d = row_d + BORDER_D;
         dcol_d = col_d;
      end
   end

   assign src_ok = (col_d < SIDE_D) && (row_d < ROWS_D);

   assign front.color    = color;
   assign front.dest_row = drow_d[COORD_W-1:0];
   assign front.dest_col = dcol_d[COORD_W-1:0];
   assign front.hit      = src_ok && (drow_d < SIDE_D) && (dcol_d < SIDE_D);
   assign front.addr     = ADDR_W'(drow_d) * ADDR_W'(SCREEN_SIDE) + ADDR_W'(dcol_d);

endmodule

`default_nettype wire

// ----- sv/lccbr_out_fifo.sv -----
// Small response queue that decouples the pipeline from the response channel.
`default_nettype none
`include "lcd_color_correct_blend_rotate_assert.svh"

module lccbr_out_fifo
   import lccbr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rsp_type               push_data,
   output      logic [FIFO_CNT_W-1:0] count,
   lccbr_rsp_if.source                rsp_bus
);

   localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
   localparam logic [FIFO_CNT_W-1:0] FULL_CNT = FIFO_CNT_W'(FIFO_DEPTH);

   rsp_type               data_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;
   rsp_type               head;

   assign head = data_ff[rd_ptr_ff];
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   assign rsp_bus.valid    = (count_ff != '0);
   assign rsp_bus.dest_row = head.dest_row;
   assign rsp_bus.dest_col = head.dest_col;
   assign rsp_bus.red      = head.color.red;
   assign rsp_bus.green    = head.color.green;
   assign rsp_bus.blue     = head.color.blue;
   assign count            = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LCCBR_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, push && !pop && count_ff == FULL_CNT)
   `LCCBR_ASSERT_IMPL(a_fifo_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT)
   `LCCBR_ASSERT_NEXT(a_fifo_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

// ----- sv/lcd_color_correct_blend_rotate.sv -----
// Throughput: one request per cycle while req_bus.ready is high; the frame store
// read is issued at acceptance and the blended value is written back the next
// cycle, with one-entry forwarding. Reset: synchronous; afterwards a clearing pass
// zeroes the 50176-entry frame store, one entry per cycle, while req_bus.ready
// stays low. Registers with a reset go to 0, except clearing_ff, which goes to 1.
`default_nettype none
`include "lcd_color_correct_blend_rotate_assert.svh"

module lcd_color_correct_blend_rotate
   import lccbr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lccbr_req_if.sink                  req_bus,
   lccbr_rsp_if.source                rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(FRAME_DEPTH - 1);
   localparam logic [FIFO_CNT_W:0]   SLOTS     = (FIFO_CNT_W + 1)'(FIFO_DEPTH);

   cfg_type               cfg_ff;
   front_type             front;
   front_type             s1_ff;
   logic                  s1_valid_ff;
   logic                  s1_blur_ff;
   logic                  clearing_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]     fwd_addr_ff;
   rgb_type               fwd_data_ff;
   logic                  accept;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [RGB_W-1:0]      rd_data;
   rgb_type               prev;
   rgb_type               blended;
   rgb_type               final_color;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   rgb_type               mem_wdata;
   rsp_type               push_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COLOR_EMULATION: cfg_ff.color_emulation <= csr_wdata[0];
            CSR_BLUR_ENABLE:     cfg_ff.blur_enable     <= csr_wdata[0];
            CSR_ROTATED:         cfg_ff.rotated         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   lccbr_convert u_convert (
      .pixel_color (req_bus.pixel_color),
      .src_col     (req_bus.src_col),
      .src_row     (req_bus.src_row),
      .cfg         (cfg_ff),
      .front       (front)
   );

   // hold off requests while clearing or while the queue could overflow
   assign req_bus.ready = !clearing_ff &&
                          (({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(s1_valid_ff)) < SLOTS);
   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= front;
         s1_blur_ff <= cfg_ff.blur_enable;
      end
   end

   lccbr_ram #(
      .WIDTH (RGB_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (accept && front.hit),
      .rd_addr (front.addr),
      .rd_data (rd_data)
   );

   // forward the write made in the cycle of this request's read
   assign prev = (fwd_valid_ff && fwd_addr_ff == s1_ff.addr) ? fwd_data_ff : rgb_type'(rd_data);

   assign blended.red   = CHAN_W'(({1'b0, s1_ff.color.red} + {1'b0, prev.red}) >> 1);
   assign blended.green = CHAN_W'(({1'b0, s1_ff.color.green} + {1'b0, prev.green}) >> 1);
   assign blended.blue  = CHAN_W'(({1'b0, s1_ff.color.blue} + {1'b0, prev.blue}) >> 1);

   assign final_color = (s1_ff.hit && s1_blur_ff) ? blended : s1_ff.color;

   assign fwd_valid_in = s1_valid_ff && s1_ff.hit;

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = fwd_valid_in;
         mem_waddr = s1_ff.addr;
         mem_wdata = final_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_ff.addr;
      fwd_data_ff <= final_color;
   end

   assign push_data.dest_row = s1_ff.dest_row;
   assign push_data.dest_col = s1_ff.dest_col;
   assign push_data.color    = final_color;

   lccbr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_data),
      .count     (fifo_count),
      .rsp_bus   (rsp_bus)
   );

   `LCCBR_ASSERT_IMPL(a_no_request_while_clearing, clock, reset, clearing_ff, !req_bus.ready)
   `LCCBR_ASSERT_IMPL(a_write_in_range, clock, reset, fwd_valid_in, s1_ff.addr <= LAST_ADDR)
   `LCCBR_ASSERT_NEXT(a_clear_ends_at_last, clock, reset, clearing_ff && clr_addr_ff != LAST_ADDR, clearing_ff)
   `LCCBR_ASSERT_IMPL(a_no_pipe_during_clear, clock, reset, clearing_ff, !s1_valid_ff && !fwd_valid_ff)

endmodule

`default_nettype wire
